FILE: design/rpf3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpf3_pkg;

	localparam int AXES    = 3;
	localparam int DATA_W  = 32;
	localparam int DT_W    = 16;
	localparam int GAIN_W  = 16;
	localparam int MUL_A_W = GAIN_W + 1;
	localparam int MUL_B_W = DATA_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int D_W     = PROD_W - 8;
	localparam int DLO_W   = 16;
	localparam int DHI_W   = D_W - DLO_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] NAT_FREQ_SQ_RESET = 16'd6400;
	localparam logic [GAIN_W-1:0] DAMPING_RESET     = 16'd2560;

	localparam logic [CFG_IDX_W-1:0] REG_NAT_FREQ_SQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 2'd1;

	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_FIRST = 2'd0;
	localparam axis_t AXIS_LAST  = axis_t'(AXES - 1);

	typedef struct packed {
		logic                     command;
		logic [DT_W-1:0]          step_time;
		logic signed [DATA_W-1:0] in_x;
		logic signed [DATA_W-1:0] in_y;
		logic signed [DATA_W-1:0] in_z;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_z;
		logic signed [DATA_W-1:0] acc_x;
		logic signed [DATA_W-1:0] acc_y;
		logic signed [DATA_W-1:0] acc_z;
	} out_item_t;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// multiplier operations, in issue order per axis
	typedef enum logic [2:0] {
		MUL_WN2_ERR,
		MUL_DAMP_ACC,
		MUL_DT_VEL,
		MUL_DT_ACC,
		MUL_DT_DLO,
		MUL_DT_DHI
	} mul_op_t;

	localparam mul_op_t MUL_FIRST = MUL_WN2_ERR;
	localparam mul_op_t MUL_LAST  = MUL_DT_DHI;

	// what is done with the registered product in the cycle after its multiply
	typedef enum logic [2:0] {
		USE_NONE,
		USE_S_SET,
		USE_S_SUB,
		USE_POS,
		USE_VEL,
		USE_TLO,
		USE_ACC
	} use_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic    capture;
		logic    load;
		mul_op_t mul_op;
		axis_t   mul_axis;
		use_op_t use_op;
		axis_t   use_axis;
		logic    load_out;
	} ctl_cmd_t;

	function automatic use_op_t use_of(input mul_op_t op);
		use_op_t r;
		unique case (op)
			MUL_WN2_ERR:  r = USE_S_SET;
			MUL_DAMP_ACC: r = USE_S_SUB;
			MUL_DT_VEL:   r = USE_POS;
			MUL_DT_ACC:   r = USE_VEL;
			MUL_DT_DLO:   r = USE_TLO;
			MUL_DT_DHI:   r = USE_ACC;
			default:      r = USE_NONE;
		endcase
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
			r = v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/rpf3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rpf3_ctrl
	import rpf3_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     in_command,
	output logic          res_valid,
	input  wire logic     res_ready,
	output ctl_cmd_t      cmd
);

	ctl_state_t state_q, state_d;
	mul_op_t    phase_q, phase_d;
	axis_t      axis_q, axis_d;
	use_op_t    use_q, use_d;
	axis_t      use_axis_q, use_axis_d;
	logic       res_valid_q;
	logic       in_acc;

	assign in_acc    = in_valid && in_ready;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= MUL_FIRST;
			axis_q      <= AXIS_FIRST;
			use_q       <= USE_NONE;
			use_axis_q  <= AXIS_FIRST;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			axis_q     <= axis_d;
			use_q      <= use_d;
			use_axis_q <= use_axis_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		axis_d       = axis_q;
		use_d        = USE_NONE;
		use_axis_d   = axis_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.mul_op   = phase_q;
		cmd.mul_axis = axis_q;
		cmd.use_op   = use_q;
		cmd.use_axis = use_axis_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				phase_d     = MUL_FIRST;
				axis_d      = AXIS_FIRST;
				if (in_valid) begin
					state_d = (in_command == CMD_LOAD) ? ST_LOAD : ST_RUN;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_RUN: begin
				use_d      = use_of(phase_q);
				use_axis_d = axis_q;
				if (phase_q == MUL_LAST) begin
					phase_d = MUL_FIRST;
					if (axis_q == AXIS_LAST) begin
						state_d = ST_DRAIN;
					end else begin
						axis_d = axis_q + axis_t'(1);
					end
				end else begin
					phase_d = mul_op_t'(phase_q + 3'd1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// wait until the output register is free
				if (!res_valid_q || res_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!res_valid_q || res_ready))
		else $error("result register overwritten while still held");

	a_use_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(use_q != USE_NONE) |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("product consumed outside of a filter step");

	a_step_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_command == CMD_STEP) |=>
			(state_q == ST_RUN && phase_q == MUL_FIRST && axis_q == AXIS_FIRST))
		else $error("filter step did not start at the first axis");

	a_drain_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_FINISH && $past(use_q) == USE_ACC))
		else $error("drain did not retire the last acceleration update");

endmodule
`default_nettype wire

FILE: design/rpf3_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rpf3_datapath
	import rpf3_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctl_cmd_t             cmd,
	input  wire in_item_t             in_item,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]    cfg_data,
	output out_item_t                 res_item
);

	in_item_t                  in_q;
	out_item_t                 out_q;
	logic [GAIN_W-1:0]         nfs_q;
	logic [GAIN_W-1:0]         damp_q;
	logic signed [DATA_W-1:0]  pos_q [AXES];
	logic signed [DATA_W-1:0]  vel_q [AXES];
	logic signed [DATA_W-1:0]  acc_q [AXES];
	logic signed [PROD_W-1:0]  s_q;
	logic [DLO_W-1:0]          t_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [DATA_W-1:0]  addend_s1;

	logic signed [DATA_W-1:0]  u_rd, p_rd, v_rd, a_rd;
	logic signed [D_W-1:0]     d_c;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [DATA_W-1:0]  addend_c;
	logic signed [SUM_W-1:0]   sum_pv;
	logic signed [SUM_W-1:0]   sum_acc;
	logic signed [DATA_W-1:0]  new_pv;
	logic signed [DATA_W-1:0]  new_acc;

	assign res_item = out_q;

	always_comb begin
		unique case (cmd.mul_axis)
			2'd0:    u_rd = in_q.in_x;
			2'd1:    u_rd = in_q.in_y;
			default: u_rd = in_q.in_z;
		endcase
	end

	assign p_rd = pos_q[cmd.mul_axis];
	assign v_rd = vel_q[cmd.mul_axis];
	assign a_rd = acc_q[cmd.mul_axis];
	assign d_c  = s_q[PROD_W-1:8];

	always_comb begin
		mul_a    = signed'({1'b0, in_q.step_time});
		mul_b    = '0;
		addend_c = '0;
		unique case (cmd.mul_op)
			MUL_WN2_ERR: begin
				mul_a = signed'({1'b0, nfs_q});
				mul_b = {u_rd[DATA_W-1], u_rd} - {v_rd[DATA_W-1], v_rd};
			end
			MUL_DAMP_ACC: begin
				mul_a = signed'({1'b0, damp_q});
				mul_b = {a_rd[DATA_W-1], a_rd};
			end
			MUL_DT_VEL: begin
				mul_b    = {v_rd[DATA_W-1], v_rd};
				addend_c = p_rd;
			end
			MUL_DT_ACC: begin
				mul_b    = {a_rd[DATA_W-1], a_rd};
				addend_c = v_rd;
			end
			MUL_DT_DLO: begin
				// low part of d is unsigned, its product stays below 2^32
				mul_b = signed'({{(MUL_B_W-DLO_W){1'b0}}, d_c[DLO_W-1:0]});
			end
			MUL_DT_DHI: begin
				mul_b    = {{(MUL_B_W-DHI_W){d_c[D_W-1]}}, d_c[D_W-1:DLO_W]};
				addend_c = a_rd;
			end
			default: begin
				mul_b = '0;
			end
		endcase
	end

	assign prod_c  = PROD_W'(mul_a * mul_b);
	assign sum_pv  = SUM_W'(addend_s1) + SUM_W'(prod_s1 >>> 16);
	// floor(dt*d/2^16) = dt*d_hi + floor(dt*d_lo/2^16)
	assign sum_acc = SUM_W'(addend_s1) + SUM_W'(prod_s1) + SUM_W'(signed'({1'b0, t_q}));
	assign new_pv  = sat32(sum_pv);
	assign new_acc = sat32(sum_acc);

	always_ff @(posedge clk) begin
		prod_s1   <= prod_c;
		addend_s1 <= addend_c;
		if (cmd.capture) begin
			in_q <= in_item;
		end
		unique case (cmd.use_op)
			USE_S_SET: s_q <= prod_s1;
			USE_S_SUB: s_q <= s_q - prod_s1;
			USE_TLO:   t_q <= prod_s1[2*DLO_W-1:DLO_W];
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_q.pos_x <= pos_q[0];
			out_q.pos_y <= pos_q[1];
			out_q.pos_z <= pos_q[2];
			out_q.vel_x <= vel_q[0];
			out_q.vel_y <= vel_q[1];
			out_q.vel_z <= vel_q[2];
			out_q.acc_x <= acc_q[0];
			out_q.acc_y <= acc_q[1];
			out_q.acc_z <= acc_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfs_q  <= NAT_FREQ_SQ_RESET;
			damp_q <= DAMPING_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_NAT_FREQ_SQ) begin
				nfs_q <= cfg_data;
			end else if (cfg_index == REG_DAMPING) begin
				damp_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else if (cmd.load) begin
			pos_q[0] <= in_q.in_x;
			pos_q[1] <= in_q.in_y;
			pos_q[2] <= in_q.in_z;
			for (int i = 0; i < AXES; i++) begin
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			unique case (cmd.use_op)
				USE_POS: pos_q[cmd.use_axis] <= new_pv;
				USE_VEL: vel_q[cmd.use_axis] <= new_pv;
				USE_ACC: acc_q[cmd.use_axis] <= new_acc;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/reference_prefilter_three_axis_core.sv
// three-axis reference prefilter: velocity command in, position, velocity and
// acceleration references out, one third-order filter per axis stepped by euler
// input channel in_valid / in_ready / in_item: command step or load, step_time dt,
// and the three axis values; output channel res_valid / res_ready / res_item holds
// the new state after every request, exactly one result per request
// configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data is always ready;
// index 0 is wn squared, index 1 the damping gain (unsigned q8.8), others ignored
// a step request runs on one shared 17x33 multiplier (6 products per axis,
// 3 axes), then a drain and an output state; the result is registered and the
// next request can be taken once the result has gone into the output register
// a load request sets positions and clears velocity and acceleration
// one request is in work at a time; a finished result sits in the output register
// while the next request is accepted, and if the receiver stalls the block holds
// its final write until the output register is free
// reset clears positions, velocities and accelerations to zero and restores the default gains
`timescale 1ns / 1ps
`default_nettype none
module reference_prefilter_three_axis_core
	import rpf3_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_item,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output out_item_t                 res_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]    cfg_data
);

	ctl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	rpf3_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_command (in_item.command),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.cmd        (cmd)
	);

	rpf3_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_item  (res_item)
	);

endmodule
`default_nettype wire
